// ===== src/ssaq_pkg.sv =====
// Shared types and constants for the single-server admission queue.
// No dependencies; imported by ssaq_ctrl, ssaq_datapath and the top level.
package ssaq_pkg;

  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned CLIENTS_W   = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [LIMIT_W-1:0]   LIMIT_RST    = 5'd4;
  localparam logic [CLIENTS_W-1:0] EXPECTED_RST = 8'd1;

  typedef enum logic [1:0] {
    MODE_FINISH = 2'd0,
    MODE_NEXT   = 2'd1,
    MODE_ARRIVE = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUEUE_LIMIT = 1'd0,
    CFG_EXPECTED    = 1'd1
  } cfg_idx_e;

  typedef enum logic {
    KIND_DISPATCH = 1'b0,
    KIND_STOP     = 1'b1
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_busy;
    logic set_busy;
    logic dec_left;
    logic push;
    logic pop;
    logic emit_stop;
    logic emit_arrival;
    logic emit_pop;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic left_zero;
    logic left_one;
    logic queue_empty;
    logic queue_room;
    logic server_busy;
  } status_t;

endpackage

// ===== src/single_server_admission_queue.sv =====
// Top level of the single-server admission queue (dispatcher with tail drop).
// Depends on ssaq_pkg, ssaq_ctrl and ssaq_datapath.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   event    | start_i, busy_o           | mode_i, client_id_i
//   result   | result_valid_o (strobe)   | result_kind_o, dispatched_id_o
//   config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An event transaction completes at a clock edge with start_i high and busy_o
// low. For most events, any result strobes in the cycle after the edge. A
// dispatch from the waiting queue passes through the registered read port of
// the waiting store and then the result register; busy_o is high for one cycle
// in between. The result strobe lasts one cycle and cannot be stalled. Reset
// is asynchronous and active low; after it the block takes events at once,
// with no clearing pass over the store.
module single_server_admission_queue
  import ssaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event transaction
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            mode_i,
  input  logic [ID_BITS-1:0]    client_id_i,
  // result strobe
  output logic                  result_valid_o,
  output logic                  result_kind_o,
  output logic [ID_BITS-1:0]    dispatched_id_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  // hold off config writes while a queue read is in flight
  assign cfg_ready_o = ~busy_o;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Sequencer: decodes each event against the queue status, issues one
  // command set, and tracks the pending store read and the stopped state.
  ssaq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Datapath: circular waiting store, occupancy, server flag, client
  // countdown, config registers and the result register.
  ssaq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .client_id_i     (client_id_i),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .result_kind_o   (result_kind_o),
    .dispatched_id_o (dispatched_id_o)
  );

  // The busy pulse of a queue read is high for exactly one cycle.
  a_pop_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  // A queue read always ends in a dispatch result.
  a_pop_dispatches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (result_valid_o && (result_kind_o == KIND_DISPATCH)))
    else $error("queue read without dispatch result");

  // Nothing follows the stop result.
  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_kind_o == KIND_STOP)) |=> !result_valid_o)
    else $error("result after stop");

endmodule

// ===== src/ssaq_ctrl.sv =====
// Event sequencer of the single-server admission queue.
// Depends on ssaq_pkg; drives the command struct of ssaq_datapath.
module ssaq_ctrl
  import ssaq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  mode_i,
  input  status_t     status_i,
  output cmd_t        cmd_o,
  output logic        busy_o
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_POP  = 3'b010,
    ST_STOP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (start_i) begin
          if (status_i.left_zero) begin
            cmd_o.emit_stop = 1'b1;
            state_d         = ST_STOP;
          end else begin
            case (mode_e'(mode_i))
              MODE_FINISH: begin
                cmd_o.clr_busy = 1'b1;
                cmd_o.dec_left = 1'b1;
                if (status_i.left_one) begin
                  cmd_o.emit_stop = 1'b1;
                  state_d         = ST_STOP;
                end
              end
              MODE_NEXT: begin
                if (!status_i.queue_empty) begin
                  cmd_o.pop      = 1'b1;
                  cmd_o.set_busy = 1'b1;
                  state_d        = ST_POP;
                end
              end
              MODE_ARRIVE: begin
                if (status_i.queue_empty && !status_i.server_busy) begin
                  cmd_o.set_busy     = 1'b1;
                  cmd_o.emit_arrival = 1'b1;
                end else if (status_i.queue_room) begin
                  cmd_o.push = 1'b1;
                end else begin
                  // drop the client, it counts as done
                  cmd_o.dec_left = 1'b1;
                  if (status_i.left_one) begin
                    cmd_o.emit_stop = 1'b1;
                    state_d         = ST_STOP;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_POP: begin
        // store read data is valid now, hand it to the output
        cmd_o.emit_pop = 1'b1;
        state_d        = ST_RUN;
      end
      ST_STOP: ;
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q == ST_POP);

endmodule

// ===== src/ssaq_datapath.sv =====
// Waiting store, pointers, counters, config registers and result register.
// Depends on ssaq_pkg; controlled by ssaq_ctrl.
module ssaq_datapath
  import ssaq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [ID_BITS-1:0]    client_id_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic                  result_kind_o,
  output logic [ID_BITS-1:0]    dispatched_id_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C   = CMP_W'(QUEUE_DEPTH);

  logic [ID_BITS-1:0]   mem_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   rd_q;
  logic [PTR_W-1:0]     head_q, tail_q;
  logic [CNT_W-1:0]     count_q;
  logic                 srv_busy_q;
  logic [CLIENTS_W-1:0] left_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 valid_q;
  logic                 kind_q;
  logic [ID_BITS-1:0]   id_q;

  logic [CMP_W-1:0] limit_ext;
  logic [CMP_W-1:0] limit_eff;

  // clamp the programmed limit to the physical depth
  assign limit_ext = CMP_W'(limit_q);
  assign limit_eff = (limit_ext > DEPTH_C) ? DEPTH_C : limit_ext;

  assign status_o.left_zero   = (left_q == '0);
  assign status_o.left_one    = (left_q == CLIENTS_W'(1));
  assign status_o.queue_empty = (count_q == '0);
  assign status_o.queue_room  = (CMP_W'(count_q) < limit_eff);
  assign status_o.server_busy = srv_busy_q;

  // waiting store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= client_id_i;
    end
    if (cmd_i.pop) begin
      rd_q <= mem_q[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      srv_busy_q <= 1'b0;
      left_q     <= EXPECTED_RST;
      limit_q    <= LIMIT_RST;
      valid_q    <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        tail_q  <= (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.pop) begin
        head_q  <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.set_busy) begin
        srv_busy_q <= 1'b1;
      end else if (cmd_i.clr_busy) begin
        srv_busy_q <= 1'b0;
      end
      if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_QUEUE_LIMIT)) begin
        limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
      // a write of the expected count loads the countdown
      if (cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_EXPECTED)) begin
        left_q <= cfg_data_i[CLIENTS_W-1:0];
      end else if (cmd_i.dec_left) begin
        left_q <= left_q - 1'b1;
      end
      valid_q <= cmd_i.emit_stop | cmd_i.emit_arrival | cmd_i.emit_pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stop) begin
      kind_q <= KIND_STOP;
      id_q   <= '0;
    end else if (cmd_i.emit_arrival) begin
      kind_q <= KIND_DISPATCH;
      id_q   <= client_id_i;
    end else if (cmd_i.emit_pop) begin
      kind_q <= KIND_DISPATCH;
      id_q   <= rd_q;
    end
  end

  assign result_valid_o  = valid_q;
  assign result_kind_o   = kind_q;
  assign dispatched_id_o = id_q;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for single_server_admission_queue: directed and random event traffic.
// Depends on ssaq_pkg and the RTL under src; holds its own dispatch predictor and result checker.
module tb_top;
  import ssaq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Mode 3 has no name in the package; the block must ignore it.
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned QUIET_TAIL    = 150;  // last random items sent without gaps
  localparam int unsigned SETTLE_CYCLES = 4;    // covers the pop path through the store read port
  localparam int unsigned DRAIN_LIMIT   = 200;

  typedef struct {
    kind_e      kind;
    logic [7:0] id;
  } dispatch_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [1:0] mode_i;
  logic [7:0] client_id_i;
  logic       result_valid_o;
  logic       result_kind_o;
  logic [7:0] dispatched_id_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  single_server_admission_queue u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .client_id_i     (client_id_i),
    .result_valid_o  (result_valid_o),
    .result_kind_o   (result_kind_o),
    .dispatched_id_o (dispatched_id_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Dispatcher shadow state: waiting ring, counters and the two registers.
  // ---------------------------------------------------------------------------
  logic [7:0] wait_ring [16];
  logic [3:0] ring_head;
  logic [3:0] ring_tail;
  logic [4:0] ring_count;
  logic       srv_busy;
  logic [7:0] left_cnt;
  logic       stopped;
  logic [4:0] limit_cfg;

  dispatch_t   pending_dispatches [$];
  int unsigned errors;
  bit          gaps_on;

  function automatic void push_dispatch(kind_e kind, logic [7:0] id);
    dispatch_t d;
    d.kind = kind;
    d.id   = id;
    pending_dispatches.push_back(d);
  endfunction

  // Mark one client done; the last one raises the stop.
  function automatic void retire_client();
    if (left_cnt != 8'd0) left_cnt = left_cnt - 8'd1;
    if (left_cnt == 8'd0) begin
      stopped = 1'b1;
      push_dispatch(KIND_STOP, 8'h00);
    end
  endfunction

  // Advance the shadow state by one accepted event and queue what it dispatches.
  function automatic void dispatch_event(logic [1:0] mode, logic [7:0] id);
    logic [4:0] cap;
    cap = (limit_cfg > 5'd16) ? 5'd16 : limit_cfg;
    if (stopped) return;
    // A count already at zero (expected_clients written as zero) stops at once.
    if (left_cnt == 8'd0) begin
      stopped = 1'b1;
      push_dispatch(KIND_STOP, 8'h00);
      return;
    end
    case (mode)
      MODE_FINISH: begin
        srv_busy = 1'b0;
        retire_client();
      end
      MODE_NEXT: begin
        if (ring_count != 5'd0) begin
          push_dispatch(KIND_DISPATCH, wait_ring[ring_head]);
          ring_head  = ring_head + 4'd1;
          ring_count = ring_count - 5'd1;
          srv_busy   = 1'b1;
        end
      end
      MODE_ARRIVE: begin
        if (ring_count == 5'd0 && !srv_busy) begin
          srv_busy = 1'b1;
          push_dispatch(KIND_DISPATCH, id);
        end else if (ring_count < cap) begin
          wait_ring[ring_tail] = id;
          ring_tail  = ring_tail + 4'd1;
          ring_count = ring_count + 5'd1;
        end else begin
          retire_client();  // tail drop
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout and result checking.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("%t timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

  // Results cannot be held off: compare each strobe against the oldest dispatch.
  always @(posedge clk_i) begin : check_dispatch
    dispatch_t want;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (pending_dispatches.size() == 0) begin
        $display("%t unexpected result: kind %0d id %02h", $time, result_kind_o,
                 dispatched_id_o);
        errors++;
      end else begin
        want = pending_dispatches.pop_front();
        if (result_kind_o !== want.kind) begin
          $display("%t result_kind mismatch: expected %0d actual %0d", $time, want.kind,
                   result_kind_o);
          errors++;
        end
        if (dispatched_id_o !== want.id) begin
          $display("%t dispatched_id mismatch: expected %02h actual %02h", $time, want.id,
                   dispatched_id_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge.
  // ---------------------------------------------------------------------------

  // Send one event transaction; optionally idle first for a burst of cycles.
  // Start stays high when the next event follows right away.
  task automatic post_event(logic [1:0] mode, logic [7:0] id);
    int unsigned gap;
    if (gaps_on && $urandom_range(5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i     <= 1'b1;
    mode_i      <= mode;
    client_id_i <= id;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    dispatch_event(mode, id);
  endtask

  // Drop start, wait for every dispatch to arrive, then let the pipeline settle.
  task automatic wait_quiet();
    int unsigned spin;
    spin = 0;
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_dispatches.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    if (pending_dispatches.size() != 0) begin
      $display("%t %0d dispatches never arrived", $time, pending_dispatches.size());
      errors++;
      pending_dispatches.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register once the block is idle.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    wait_quiet();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_QUEUE_LIMIT: limit_cfg = data[LIMIT_W-1:0];
      CFG_EXPECTED:    left_cnt  = data;  // also reloads the clients left
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limit of four: dispatch straight, fill the queue, drop at the tail.
  task automatic test_fill_and_drop();
    write_reg(CFG_EXPECTED, 8'hFF);
    post_event(MODE_ARRIVE, 8'h00);
    post_event(MODE_ARRIVE, 8'hFF);
    post_event(MODE_ARRIVE, 8'h55);
    post_event(MODE_ARRIVE, 8'hAA);
    post_event(MODE_ARRIVE, 8'h01);
    post_event(MODE_ARRIVE, 8'h80);
  endtask

  // Lower the limit under the waiting count: keep the waiting, drop arrivals until it falls under.
  task automatic test_shrink_limit();
    write_reg(CFG_QUEUE_LIMIT, 8'd2);
    post_event(MODE_ARRIVE, 8'h7F);
    post_event(MODE_NEXT,   8'h00);
    post_event(MODE_NEXT,   8'hFF);
    post_event(MODE_ARRIVE, 8'h3C);
    post_event(MODE_NEXT,   8'h12);
    post_event(MODE_ARRIVE, 8'hC3);
    post_event(MODE_NEXT,   8'h00);
    post_event(MODE_NEXT,   8'h00);
    post_event(MODE_NEXT,   8'hFF);  // empty queue, nothing to dispatch
  endtask

  // Zero limit, an unused mode and a finish while the server is idle.
  task automatic test_zero_limit();
    write_reg(CFG_QUEUE_LIMIT, 8'hE0);  // upper data bits fall outside the register
    post_event(MODE_FINISH, 8'h5A);
    post_event(MODE_UNUSED, 8'hFF);
    post_event(MODE_ARRIVE, 8'h12);
    post_event(MODE_ARRIVE, 8'h34);
    post_event(MODE_FINISH, 8'h12);
    post_event(MODE_FINISH, 8'hA5);
  endtask

  // Phases of random traffic. Each phase picks a limit (extremes included), reloads
  // the client count high enough that no stop can occur, and a mode mix that either
  // fills the queue toward its limit or drains it through request/finish cycles.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned arrive_w;
    int unsigned r;
    logic [4:0]  lim;
    logic [1:0]  mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0:       lim = 5'd0;
        1:       lim = 5'd16;
        2:       lim = 5'd31;
        default: lim = 5'($urandom_range(1, 15));
      endcase
      write_reg(CFG_QUEUE_LIMIT, {3'($urandom_range(7)), lim});
      write_reg(CFG_EXPECTED, ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(64, 254)));
      phase_len = $urandom_range(10, 60);
      arrive_w  = $urandom_range(25, 70);
      gaps_on   = (sent + QUIET_TAIL < RANDOM_ITEMS) && ($urandom_range(3) != 0);
      repeat (phase_len) begin
        r = $urandom_range(99);
        if (r < 3)                                  mode = MODE_UNUSED;
        else if (r < 3 + arrive_w)                  mode = MODE_ARRIVE;
        else if (r < 3 + arrive_w + (97 - arrive_w) / 2) mode = MODE_NEXT;
        else                                        mode = MODE_FINISH;
        post_event(mode, 8'($urandom));
      end
      sent += phase_len;
    end
    gaps_on = 1'b0;
  endtask

  // Stop is final without a reset, so only one ending fits in a run: the seed picks
  // either a zero client count or a count-down through finishes and tail drops.
  // Afterward every event must be ignored.
  task automatic test_stop();
    if ($urandom_range(1) == 0) begin
      write_reg(CFG_EXPECTED, 8'd0);
      post_event(MODE_ARRIVE, 8'($urandom));
    end else begin
      write_reg(CFG_QUEUE_LIMIT, 8'd0);
      write_reg(CFG_EXPECTED, 8'($urandom_range(1, 3)));
      while (!stopped)
        post_event(($urandom_range(1) == 0) ? MODE_FINISH : MODE_ARRIVE, 8'($urandom));
    end
    repeat (8) post_event(2'($urandom_range(3)), 8'($urandom));
  endtask

  initial begin
    errors      = 0;
    gaps_on     = 1'b0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = MODE_FINISH;
    client_id_i = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_QUEUE_LIMIT;
    cfg_data_i  = 8'h00;
    ring_head   = 4'd0;
    ring_tail   = 4'd0;
    ring_count  = 5'd0;
    srv_busy    = 1'b0;
    stopped     = 1'b0;
    limit_cfg   = LIMIT_RST;
    left_cnt    = EXPECTED_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_drop();
    test_shrink_limit();
    test_zero_limit();
    test_random_traffic();
    test_stop();

    wait_quiet();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
